// ----- src/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Calibration layout, queued item format and fixed-point constants of the
// barometric compensation datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // Calibration register indexes
  localparam logic [2:0] REG_T1_T2 = 3'd0;
  localparam logic [2:0] REG_T3_P1 = 3'd1;
  localparam logic [2:0] REG_P2_P3 = 3'd2;
  localparam logic [2:0] REG_P4_P5 = 3'd3;
  localparam logic [2:0] REG_P6_P7 = 3'd4;
  localparam logic [2:0] REG_P8_P9 = 3'd5;

  // Fixed-point constants
  localparam logic signed [63:0] TF_OFFSET  = 64'sd128000;
  localparam logic signed [63:0] PRESS_BASE = 64'sd1048576;
  localparam logic signed [63:0] DIV_SCALE  = 64'sd3125;
  localparam logic signed [63:0] P1_BIAS    = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] TEMP_ROUND = 64'sd128;
  localparam logic signed [63:0] TEMP_MAX   = 64'sd8388607;
  localparam logic signed [63:0] TEMP_MIN   = -64'sd8388608;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // Request as held between front and back
  typedef struct packed {
    logic        [19:0] adc_press;
    logic signed [17:0] d1;
    logic signed [16:0] d2;
  } item_t;

endpackage

`default_nettype wire

// ----- src/bsc_mul.sv -----
// ----------------------------------------------------------------------------
// bsc_mul: iterative 64-bit multiplier
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_mul import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic      [63:0] p
);

  logic        busy;
  logic [1:0]  phase;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mx;
  logic [31:0] my;

  // Select partial product operands
  always_comb begin
    unique case (phase)
      2'd0: begin mx = opa[31:0];  my = opb[31:0];  end
      2'd1: begin mx = opa[31:0];  my = opb[63:32]; end
      2'd2: begin mx = opa[63:32]; my = opb[31:0];  end
      default: begin mx = '0; my = '0; end
    endcase
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial products and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
      opb <= b;
    end
    if (busy) begin
      prod <= {32'b0, mx} * {32'b0, my};
      unique case (phase)
        2'd0: acc <= acc;
        2'd1: acc <= prod;
        default: acc <= acc + {prod[31:0], 32'b0};
      endcase
    end
  end

  assign p = acc;

endmodule

`default_nettype wire

// ----- src/bsc_div.sv -----
// ----------------------------------------------------------------------------
// bsc_div: iterative signed divider
// 64-bit quotient truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_div import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic      [63:0] q
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] ub;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  assign rem_sh = {rem, quo[63]};
  assign diff   = rem_sh - {1'b0, ub};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring shift-subtract on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[63] ^ den[63];
      quo <= num[63] ? 64'd0 - num : num;
      ub  <= den[63] ? 64'd0 - den : den;
      rem <= '0;
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign q = neg ? 64'd0 - quo : quo;

endmodule

`default_nettype wire

// ----- src/bsc_front.sv -----
// ----------------------------------------------------------------------------
// bsc_front: request intake
// Accepts raw readings, forms the temperature differences and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_front import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [19:0] adc_temp,
  input  wire logic [19:0] adc_press,
  input  wire logic [15:0] t1,
  input  wire logic        deq,
  output logic             q_valid,
  output item_t            q_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       do_push;
  logic       do_pop;

  // Form the temperature differences
  always_comb begin
    in_item.adc_press = adc_press;
    in_item.d1 = $signed({1'b0, adc_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
    in_item.d2 = $signed({1'b0, adc_temp[19:4]}) - $signed({1'b0, t1});
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = deq && q_valid;
  assign q_item  = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store request
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= in_item;
  end

endmodule

`default_nettype wire

// ----- src/bsc_back.sv -----
// ----------------------------------------------------------------------------
// bsc_back: compensation engine
// Sequences the temperature and pressure formulas over a shared multiplier
// and divider, and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_back import bsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire calib_t             calib,
  input  wire logic               q_valid,
  input  wire item_t              q_item,
  output logic                    deq,
  output logic signed [23:0]      temp_centi,
  output logic        [31:0]      press_q24_8,
  output logic                    press_valid,
  output logic                    empty,
  input  wire logic               pop
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    STEP_D1T2, STEP_D2SQ, STEP_T3, STEP_AA, STEP_P6, STEP_P5, STEP_P3,
    STEP_P2, STEP_P1, STEP_NUM, STEP_P9A, STEP_P9B, STEP_P8
  } step_t;

  state_t state;
  step_t  step;

  // Working registers
  logic        [19:0] adcp;
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [63:0] ta, tm, tf, aa, bv, a2, a3, qv, m1, ma;
  logic        [31:0] pres;
  logic               pvalid;
  logic               out_full;

  // Arithmetic units
  logic               mul_start, mul_done, div_start, div_done;
  logic        [63:0] mul_x, mul_y, mul_p, div_q;
  logic signed [63:0] mp, av, pr, p_final, tt, tsat;
  logic signed [63:0] a3_new;
  logic               load_out;

  bsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_x),
    .b     (mul_y),
    .done  (mul_done),
    .p     (mul_p)
  );

  bsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_p),
    .den   (a3),
    .done  (div_done),
    .q     (div_q)
  );

  assign mp        = $signed(mul_p);
  assign av        = tf - TF_OFFSET;
  assign pr        = PRESS_BASE - $signed({44'b0, adcp});
  assign a3_new    = mp >>> 33;
  assign mul_start = (state == ST_ISSUE);
  assign div_start = (state == ST_WAIT) && mul_done && (step == STEP_NUM);
  assign deq       = (state == ST_IDLE) && q_valid;
  assign load_out  = (state == ST_EMIT) && (!out_full || pop);
  assign empty     = !out_full;
  assign p_final   = ((qv + ma + (mp >>> 19)) >>> 8) + (64'(calib.p7) <<< 4);

  // Select multiplier operands for the current step
  always_comb begin
    unique case (step)
      STEP_D1T2: begin mul_x = 64'(d1);          mul_y = 64'(calib.t2); end
      STEP_D2SQ: begin mul_x = 64'(d2);          mul_y = 64'(d2);       end
      STEP_T3:   begin mul_x = tm;               mul_y = 64'(calib.t3); end
      STEP_AA:   begin mul_x = av;               mul_y = av;            end
      STEP_P6:   begin mul_x = aa;               mul_y = 64'(calib.p6); end
      STEP_P5:   begin mul_x = av;               mul_y = 64'(calib.p5); end
      STEP_P3:   begin mul_x = aa;               mul_y = 64'(calib.p3); end
      STEP_P2:   begin mul_x = av;               mul_y = 64'(calib.p2); end
      STEP_P1:   begin mul_x = a2 + P1_BIAS;     mul_y = {48'b0, calib.p1}; end
      STEP_NUM:  begin mul_x = (pr <<< 31) - bv; mul_y = DIV_SCALE;     end
      STEP_P9A:  begin mul_x = 64'(calib.p9);    mul_y = qv >>> 13;     end
      STEP_P9B:  begin mul_x = m1;               mul_y = qv >>> 13;     end
      STEP_P8:   begin mul_x = 64'(calib.p8);    mul_y = qv;            end
      default:   begin mul_x = '0;               mul_y = '0;            end
    endcase
  end

  // Round and saturate the temperature
  always_comb begin
    tt = (tf + (tf <<< 2) + TEMP_ROUND) >>> 8;
    priority if (tt > TEMP_MAX) begin
      tsat = TEMP_MAX;
    end else if (tt < TEMP_MIN) begin
      tsat = TEMP_MIN;
    end else begin
      tsat = tt;
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_D1T2;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            step  <= STEP_D1T2;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done) begin
            if (step == STEP_P1 && a3_new == 64'sd0) begin
              state <= ST_EMIT;
            end else if (step == STEP_NUM) begin
              state <= ST_DIV;
            end else if (step == STEP_P8) begin
              state <= ST_EMIT;
            end else begin
              step  <= step_t'(step + 4'd1);
              state <= ST_ISSUE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step  <= STEP_P9A;
            state <= ST_ISSUE;
          end
        end
        ST_EMIT: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture request and write back step results
  always_ff @(posedge clk) begin
    if (deq) begin
      adcp <= q_item.adc_press;
      d1   <= q_item.d1;
      d2   <= q_item.d2;
    end
    if (state == ST_DIV && div_done) qv <= $signed(div_q);
    if (state == ST_WAIT && mul_done) begin
      unique case (step)
        STEP_D1T2: ta <= mp >>> 11;
        STEP_D2SQ: tm <= mp >>> 12;
        STEP_T3:   tf <= ta + (mp >>> 14);
        STEP_AA:   aa <= mp;
        STEP_P6:   bv <= mp;
        STEP_P5:   bv <= bv + (mp <<< 17) + (64'(calib.p4) <<< 35);
        STEP_P3:   a2 <= mp >>> 8;
        STEP_P2:   a2 <= a2 + (mp <<< 12);
        STEP_P1: begin
          a3 <= a3_new;
          if (a3_new == 64'sd0) begin
            pres   <= '0;
            pvalid <= 1'b0;
          end
        end
        STEP_NUM:  a3 <= a3;
        STEP_P9A:  m1 <= mp;
        STEP_P9B:  ma <= mp >>> 25;
        STEP_P8: begin
          pres   <= p_final[31:0];
          pvalid <= 1'b1;
        end
        default: ta <= ta;
      endcase
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (load_out) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      temp_centi  <= tsat[23:0];
      press_q24_8 <= pres;
      press_valid <= pvalid;
    end
  end

endmodule

`default_nettype wire

// ----- src/baro_sensor_compensation.sv -----
// Requests are worked on one at a time; each takes thirteen passes through the
// shared multiplier and a run of the one-bit-per-cycle 64-bit divider, but
// stops after the P1 step without dividing when the pressure divisor is zero.
// Two requests queue at the input and one result waits at the output.
// Reset: synchronous, active high; clears the queues and calibration to zero.
// ----------------------------------------------------------------------------
// baro_sensor_compensation: barometric sensor compensation
// Turns raw temperature and pressure readings into compensated values using
// six packed calibration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation import bsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [19:0] adc_temp,
  input  wire logic        [19:0] adc_press,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed      [23:0] temp_centi,
  output logic             [31:0] press_q24_8,
  output logic                    press_valid,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  calib_t calib;
  logic   q_valid;
  logic   deq;
  item_t  q_item;

  assign cfg_ready = 1'b1;

  // Write calibration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_T1_T2: begin calib.t1 <= cfg_data[15:0]; calib.t2 <= cfg_data[31:16]; end
        REG_T3_P1: begin calib.t3 <= cfg_data[15:0]; calib.p1 <= cfg_data[31:16]; end
        REG_P2_P3: begin calib.p2 <= cfg_data[15:0]; calib.p3 <= cfg_data[31:16]; end
        REG_P4_P5: begin calib.p4 <= cfg_data[15:0]; calib.p5 <= cfg_data[31:16]; end
        REG_P6_P7: begin calib.p6 <= cfg_data[15:0]; calib.p7 <= cfg_data[31:16]; end
        REG_P8_P9: begin calib.p8 <= cfg_data[15:0]; calib.p9 <= cfg_data[31:16]; end
        default: calib <= calib;
      endcase
    end
  end

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .adc_temp  (adc_temp),
    .adc_press (adc_press),
    .t1        (calib.t1),
    .deq       (deq),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  bsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .calib       (calib),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .deq         (deq),
    .temp_centi  (temp_centi),
    .press_q24_8 (press_q24_8),
    .press_valid (press_valid),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire
